// ===== rtl/core/pmr_pkg.sv =====
// Shared types and constants for the packet mailbox ring.
// Holds the result status codes and the result word that travels to the output queue.
// No dependencies.
package pmr_pkg;

	// Status codes reported with every result.
	typedef enum logic [2:0] {
		RS_STORED      = 3'd0,
		RS_STORED_DROP = 3'd1,
		RS_REFUSED     = 3'd2,
		RS_TAKEN       = 3'd3,
		RS_EMPTY       = 3'd4,
		RS_TOO_BIG     = 3'd5
	} res_status_t;

	// Slot count after reset, and the ceiling of the reader capacity.
	localparam logic [3:0] SLOT_COUNT_RST = 4'd8;
	localparam logic [6:0] CAP_MAX        = 7'd64;

	// One result item as it waits in the output queue.
	typedef struct packed {
		res_status_t status;
		logic [7:0]  data;
		logic        last;
		logic [6:0]  length;
		logic [3:0]  held;
		logic [31:0] dropped;
		logic [31:0] refused;
	} result_t;

endpackage

// ===== rtl/core/pmr_ring_mem.sv =====
// Storage of the packet mailbox ring: packet bytes, slot lengths and the ring slot map.
// All reads are synchronous and registered; read data holds until the next read.
// Depends on nothing but its parameters.
module pmr_ring_mem #(
	parameter int SLOTS            = 8,
	parameter int MAX_PACKET_BYTES = 64
) (
	clk,
	arst_n,
	ord_clr,
	ord_we,
	ord_waddr,
	ord_wdata,
	ord_re,
	ord_raddr,
	ord_rdata,
	len_we,
	len_waddr,
	len_wdata,
	len_re,
	len_raddr,
	len_rdata,
	byte_we,
	byte_waddr,
	byte_wdata,
	byte_re,
	byte_raddr,
	byte_rdata
);
	localparam int SW = $clog2(SLOTS + 1);
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int BD = (SLOTS + 1) * MAX_PACKET_BYTES;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;

	input  logic          clk;
	input  logic          arst_n;
	input  logic          ord_clr;
	input  logic          ord_we;
	input  logic [PW-1:0] ord_waddr;
	input  logic [SW-1:0] ord_wdata;
	input  logic          ord_re;
	input  logic [PW-1:0] ord_raddr;
	output logic [SW-1:0] ord_rdata;
	input  logic          len_we;
	input  logic [SW-1:0] len_waddr;
	input  logic [LW-1:0] len_wdata;
	input  logic          len_re;
	input  logic [SW-1:0] len_raddr;
	output logic [LW-1:0] len_rdata;
	input  logic          byte_we;
	input  logic [AW-1:0] byte_waddr;
	input  logic [7:0]    byte_wdata;
	input  logic          byte_re;
	input  logic [AW-1:0] byte_raddr;
	output logic [7:0]    byte_rdata;

	logic [SW-1:0] ord_mem [SLOTS];
	logic [LW-1:0] len_mem [SLOTS+1];
	logic [7:0]    byte_mem [BD];

	logic [SLOTS-1:0] ord_vld_q;
	logic             ord_rvld_q;
	logic [PW-1:0]    ord_raddr_q;
	logic [SW-1:0]    ord_rraw_q;

	// Valid bits of the slot map; a position never written maps to its own slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_vld_q <= '0;
		end else if (ord_clr) begin
			ord_vld_q <= '0;
		end else if (ord_we) begin
			ord_vld_q[ord_waddr] <= 1'b1;
		end
	end

	// Slot map array with registered read.
	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		if (ord_re) begin
			ord_rraw_q  <= ord_mem[ord_raddr];
			ord_rvld_q  <= ord_vld_q[ord_raddr];
			ord_raddr_q <= ord_raddr;
		end
	end

	assign ord_rdata = ord_rvld_q ? ord_rraw_q : SW'(ord_raddr_q);

	// Slot length array.
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (len_re) begin
			len_rdata <= len_mem[len_raddr];
		end
	end

	// Packet byte array, one region of MAX_PACKET_BYTES per physical slot.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_waddr] <= byte_wdata;
		end
		if (byte_re) begin
			byte_rdata <= byte_mem[byte_raddr];
		end
	end

endmodule

// ===== rtl/core/pmr_out_q.sv =====
// Two-entry result queue that parts the ring logic from the output channel.
// Depends on pmr_pkg for the result word.
module pmr_out_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pmr_pkg::result_t push_data,
	input  logic             pop,
	output logic [1:0]       count,
	output pmr_pkg::result_t head
);
	import pmr_pkg::*;

	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] count_q;
	logic [1:0] wr_slot;

	// Fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The pushed entry lands behind whatever remains after the pop.
	assign wr_slot = count_q - {1'b0, pop};

	always_ff @(posedge clk) begin
		if (pop && count_q == 2'd2) begin
			ent0_q <= ent1_q;
		end
		if (push) begin
			if (wr_slot == 2'd0) begin
				ent0_q <= push_data;
			end else begin
				ent1_q <= push_data;
			end
		end
	end

	assign count = count_q;
	assign head  = ent0_q;

endmodule

// ===== rtl/core/pdu_mailbox_ring_drop_oldest_core.sv =====
// Top level of the packet mailbox ring with drop-oldest overflow.
// Depends on pmr_pkg, pmr_ring_mem and pmr_out_q.
//
// Usage:
// Input items arrive on in_valid / in_stall. A put item (action 0) carries one packet
// byte; bytes without the last mark are taken one per cycle while in_stall is low and
// give no result. The put with the last mark commits the packet and gives one status
// result, pushed from ST_PUT_SWAP (in the accepting cycle for a refusal). A take item
// (action 1) gives an empty or too-big status, or the packet bytes with the last mark
// on the final byte. An empty take pushes its status in the accepting cycle, a too-big
// take in ST_TAKE_LEN. The first packet byte follows the slot-map, slot-length and byte
// reads, each registered in its memory; then one byte per cycle while out_stall is low.
// The block takes one item at a time: in_stall stays high from a committing put or a
// non-empty take until its results are all queued (and through ST_DRAIN after a
// streamed packet), and while the two-entry result queue is full and not popped. A
// stalled receiver therefore backs up into in_stall; no result is lost.
// cfg_wr_en writes slot_count and empties the ring; the drop and refusal counters stay.
// Reset empties the ring, clears both counters and sets slot_count to 8. The slot map
// has a valid bit per entry, so there is no clearing pass after reset.
module pdu_mailbox_ring_drop_oldest_core #(
	parameter int SLOTS            = 8,
	parameter int MAX_PACKET_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [6:0]  capacity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [6:0]  packet_length,
	output logic [3:0]  packets_held,
	output logic [31:0] dropped_total,
	output logic [31:0] refused_total
);
	import pmr_pkg::*;

	localparam int SW = $clog2(SLOTS + 1);
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int OW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
	localparam int BD = (SLOTS + 1) * MAX_PACKET_BYTES;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;
	localparam int CW = (SW > 4) ? SW : 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT_SWAP,
		ST_TAKE_ORD,
		ST_TAKE_LEN,
		ST_STREAM,
		ST_DRAIN
	} state_t;

	state_t        state_q;
	logic [3:0]    slot_count_q;
	logic [PW-1:0] head_q;
	logic [SW-1:0] held_q;
	logic [LW-1:0] stl_q;
	logic          ovf_q;
	logic [31:0]   dropped_q;
	logic [31:0]   refused_q;
	logic [SW-1:0] stage_q;
	logic          drop_q;
	logic [PW-1:0] pos_q;
	logic [SW-1:0] phys_q;
	logic [6:0]    cap_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;
	logic          pend_s1;
	logic          last_s1;

	logic [SW-1:0] n_w;
	logic          in_fire;
	logic          stl_full;
	logic          refuse_w;
	logic          ring_empty;
	logic          drop_w;
	logic [SW:0]   hp1_w;
	logic [PW-1:0] head_adv;
	logic [PW-1:0] head_d;
	logic [SW-1:0] held_d;
	logic [SW:0]   sum_w;
	logic [PW-1:0] pos_w;
	logic [6:0]    cap_sat;
	logic          stream_last;
	logic [2:0]    occ_w;
	logic          issue_w;

	logic          ord_we;
	logic [PW-1:0] ord_waddr;
	logic [SW-1:0] ord_wdata;
	logic          ord_re;
	logic [PW-1:0] ord_raddr;
	logic [SW-1:0] ord_rdata;
	logic          len_we;
	logic [SW-1:0] len_waddr;
	logic [LW-1:0] len_wdata;
	logic          len_re;
	logic [SW-1:0] len_raddr;
	logic [LW-1:0] len_rdata;
	logic          byte_we;
	logic [AW-1:0] byte_waddr;
	logic          byte_re;
	logic [AW-1:0] byte_raddr;
	logic [7:0]    byte_rdata;

	logic          q_push;
	result_t       q_push_data;
	logic          q_pop;
	logic [1:0]    q_count;
	result_t       q_head;

	// Effective slot count: register values above SLOTS act as SLOTS.
	assign n_w = (CW'(slot_count_q) > CW'(SLOTS)) ? SW'(SLOTS) : SW'(slot_count_q);

	// Output channel and input acceptance.
	assign q_pop     = (q_count != 2'd0) && !out_stall;
	assign out_valid = (q_count != 2'd0);
	assign in_stall  = (state_q != ST_IDLE) || ((q_count == 2'd2) && !q_pop);
	assign in_fire   = in_valid && !in_stall;

	// Put decisions.
	assign stl_full   = (stl_q >= LW'(MAX_PACKET_BYTES));
	assign refuse_w   = ovf_q || stl_full || (n_w == '0);
	assign ring_empty = (held_q == '0) || (n_w == '0);
	assign drop_w     = (held_q >= n_w);

	// Ring position arithmetic modulo the slot count; every sum stays below 2n.
	assign hp1_w    = (SW+1)'(head_q) + (SW+1)'(1);
	assign head_adv = (hp1_w == (SW+1)'(n_w)) ? '0 : PW'(hp1_w);
	assign head_d   = drop_w ? head_adv : head_q;
	assign held_d   = drop_w ? (held_q - SW'(1)) : held_q;
	assign sum_w    = (SW+1)'(head_d) + (SW+1)'(held_d);
	assign pos_w    = (sum_w >= (SW+1)'(n_w)) ? PW'(sum_w - (SW+1)'(n_w)) : PW'(sum_w);

	assign cap_sat     = (capacity > CAP_MAX) ? CAP_MAX : capacity;
	assign stream_last = (idx_q == (len_q - LW'(1)));

	// A byte read is issued only when the queue is sure to have room for its data.
	assign occ_w   = 3'(q_count) + 3'(pend_s1) - 3'(q_pop);
	assign issue_w = (state_q == ST_STREAM) && (occ_w < 3'd2);

	// Memory requests and result pushes.
	always_comb begin
		ord_we      = 1'b0;
		ord_waddr   = pos_q;
		ord_wdata   = stage_q;
		ord_re      = 1'b0;
		ord_raddr   = head_q;
		len_we      = 1'b0;
		len_waddr   = stage_q;
		len_wdata   = stl_q + LW'(1);
		len_re      = 1'b0;
		len_raddr   = ord_rdata;
		byte_we     = 1'b0;
		byte_waddr  = AW'(stage_q) * AW'(MAX_PACKET_BYTES) + AW'(stl_q[OW-1:0]);
		byte_re     = issue_w;
		byte_raddr  = AW'(phys_q) * AW'(MAX_PACKET_BYTES) + AW'(idx_q[OW-1:0]);
		q_push      = 1'b0;
		q_push_data = '{status: RS_STORED, data: 8'd0, last: 1'b1, length: 7'd0,
			held: 4'(held_q), dropped: dropped_q, refused: refused_q};
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (!action) begin
						byte_we = !stl_full;
						if (last_byte) begin
							if (refuse_w) begin
								q_push                 = 1'b1;
								q_push_data.status     = RS_REFUSED;
								q_push_data.refused    = refused_q + 32'd1;
							end else begin
								ord_re    = 1'b1;
								ord_raddr = pos_w;
								len_we    = 1'b1;
							end
						end
					end else if (ring_empty) begin
						q_push             = 1'b1;
						q_push_data.status = RS_EMPTY;
					end else begin
						ord_re = 1'b1;
					end
				end
			end
			ST_PUT_SWAP: begin
				ord_we             = 1'b1;
				q_push             = 1'b1;
				q_push_data.status = drop_q ? RS_STORED_DROP : RS_STORED;
			end
			ST_TAKE_ORD: begin
				len_re = 1'b1;
			end
			ST_TAKE_LEN: begin
				if (7'(len_rdata) > cap_q) begin
					q_push             = 1'b1;
					q_push_data.status = RS_TOO_BIG;
					q_push_data.length = 7'(len_rdata);
				end else if (len_rdata == '0) begin
					q_push             = 1'b1;
					q_push_data.status = RS_TAKEN;
				end
			end
			default: begin
			end
		endcase
		// Byte data returning from memory goes straight into the queue.
		if (pend_s1) begin
			q_push             = 1'b1;
			q_push_data.status = RS_TAKEN;
			q_push_data.data   = byte_rdata;
			q_push_data.last   = last_s1;
			q_push_data.length = 7'(len_q);
		end
	end

	// Control sequencer and ring state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_count_q <= SLOT_COUNT_RST;
			head_q       <= '0;
			held_q       <= '0;
			stl_q        <= '0;
			ovf_q        <= 1'b0;
			dropped_q    <= '0;
			refused_q    <= '0;
			stage_q      <= SW'(SLOTS);
			drop_q       <= 1'b0;
			pos_q        <= '0;
			phys_q       <= '0;
			cap_q        <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			pend_s1 <= issue_w;
			if (issue_w) begin
				last_s1 <= stream_last;
			end
			if (cfg_wr_en) begin
				slot_count_q <= cfg_wr_data;
				head_q       <= '0;
				held_q       <= '0;
				stl_q        <= '0;
				ovf_q        <= 1'b0;
				stage_q      <= SW'(SLOTS);
				state_q      <= ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_fire) begin
							if (!action) begin
								if (!last_byte) begin
									if (stl_full) begin
										ovf_q <= 1'b1;
									end else begin
										stl_q <= stl_q + LW'(1);
									end
								end else begin
									stl_q <= '0;
									ovf_q <= 1'b0;
									if (refuse_w) begin
										refused_q <= refused_q + 32'd1;
									end else begin
										head_q  <= head_d;
										held_q  <= held_d + SW'(1);
										drop_q  <= drop_w;
										pos_q   <= pos_w;
										state_q <= ST_PUT_SWAP;
										if (drop_w) begin
											dropped_q <= dropped_q + 32'd1;
										end
									end
								end
							end else if (!ring_empty) begin
								head_q  <= head_adv;
								held_q  <= held_q - SW'(1);
								cap_q   <= cap_sat;
								state_q <= ST_TAKE_ORD;
							end
						end
					end
					ST_PUT_SWAP: begin
						// The slot displaced from the ring becomes the new staging slot.
						stage_q <= ord_rdata;
						state_q <= ST_IDLE;
					end
					ST_TAKE_ORD: begin
						phys_q  <= ord_rdata;
						state_q <= ST_TAKE_LEN;
					end
					ST_TAKE_LEN: begin
						len_q <= len_rdata;
						idx_q <= '0;
						if ((7'(len_rdata) > cap_q) || (len_rdata == '0)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_STREAM;
						end
					end
					ST_STREAM: begin
						if (issue_w) begin
							idx_q <= idx_q + LW'(1);
							if (stream_last) begin
								state_q <= ST_DRAIN;
							end
						end
					end
					ST_DRAIN: begin
						if (!pend_s1) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	pmr_ring_mem #(
		.SLOTS           (SLOTS),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ord_clr   (cfg_wr_en),
		.ord_we    (ord_we),
		.ord_waddr (ord_waddr),
		.ord_wdata (ord_wdata),
		.ord_re    (ord_re),
		.ord_raddr (ord_raddr),
		.ord_rdata (ord_rdata),
		.len_we    (len_we),
		.len_waddr (len_waddr),
		.len_wdata (len_wdata),
		.len_re    (len_re),
		.len_raddr (len_raddr),
		.len_rdata (len_rdata),
		.byte_we   (byte_we),
		.byte_waddr(byte_waddr),
		.byte_wdata(data_byte),
		.byte_re   (byte_re),
		.byte_raddr(byte_raddr),
		.byte_rdata(byte_rdata)
	);

	pmr_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.count    (q_count),
		.head     (q_head)
	);

	// Result fields come from the head of the queue.
	assign status        = q_head.status;
	assign out_byte      = q_head.data;
	assign out_last      = q_head.last;
	assign packet_length = q_head.length;
	assign packets_held  = q_head.held;
	assign dropped_total = q_head.dropped;
	assign refused_total = q_head.refused;

	// The queue never overfills.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_count == 2'd2 && q_push && !q_pop))
		else $error("result queue overflow");

	// The ring never holds more packets than the effective slot count.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= n_w)
		else $error("held count exceeds slot count");

	// The head position stays inside the ring.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) || ((SW+1)'(head_q) < (SW+1)'(n_w)))
		else $error("head position outside ring");

	// Returning byte data belongs to a take that is still streaming.
	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_STREAM || state_q == ST_DRAIN))
		else $error("byte data returned outside a take");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the packet mailbox ring with drop-oldest overflow.
// A behavioral copy of the ring predicts every result, and each output transfer is
// checked field by field. Depends on pmr_pkg and pdu_mailbox_ring_drop_oldest_core.
module tb_top;
	import pmr_pkg::*;

	localparam int NSLOT = 8;
	localparam int MAXB = 64;
	localparam logic ACT_PUT = 1'b0;
	localparam logic ACT_TAKE = 1'b1;
	localparam int TAIL_CYCLES = 20;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 150;
	localparam int PRINT_LIMIT = 30;

	typedef struct {
		logic       act;
		logic [7:0] db;
		logic       lb;
		logic [6:0] cap;
	} ring_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [3:0]  cfg_wr_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_PUT;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic [6:0]  capacity = 7'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [6:0]  packet_length;
	logic [3:0]  packets_held;
	logic [31:0] dropped_total;
	logic [31:0] refused_total;

	// Stimulus and expectation stores.
	ring_op_t ops_to_send[$];
	result_t  results_due[$];
	int       queued_cnt = 0;
	int       accepted_cnt = 0;
	int       result_cnt = 0;
	int       err_cnt = 0;
	logic     in_xfer = 1'b0;
	int       snd_idle_pct = 0;
	int       rcv_idle_pct = 0;
	bit       hold_armed = 1'b0;
	bit       hold_started = 1'b0;
	int       hold_left = 0;
	int       quiet_cycles = 0;

	// Behavioral copy of the ring.
	logic [7:0]  mb_bytes [0:NSLOT][0:MAXB-1];
	logic [6:0]  mb_len [0:NSLOT];
	int          mb_order [0:NSLOT];
	int          mb_head;
	int          mb_held;
	int          mb_stage_len;
	bit          mb_ovf;
	logic [31:0] mb_dropped;
	logic [31:0] mb_refused;
	logic [3:0]  mb_slots;

	pdu_mailbox_ring_drop_oldest_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.capacity(capacity),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_byte(out_byte),
		.out_last(out_last),
		.packet_length(packet_length),
		.packets_held(packets_held),
		.dropped_total(dropped_total),
		.refused_total(refused_total)
	);

	always #5 clk = ~clk;

	// A slot count write empties the ring and the staging slot; counters stay.
	function automatic void ring_config(input logic [3:0] value);
		mb_slots = value;
		for (int i = 0; i <= NSLOT; i++) begin
			mb_order[i] = i;
		end
		mb_head = 0;
		mb_held = 0;
		mb_stage_len = 0;
		mb_ovf = 1'b0;
	endfunction

	function automatic void due_result(input res_status_t st, input logic [7:0] b,
			input logic l, input int len);
		result_t r;
		r.status = st;
		r.data = b;
		r.last = l;
		r.length = 7'(len);
		r.held = 4'(mb_held);
		r.dropped = mb_dropped;
		r.refused = mb_refused;
		results_due.push_back(r);
	endfunction

	// Expected results of one accepted transfer, with the ring state advanced.
	function automatic void ring_step(input logic act, input logic [7:0] db,
			input logic lb, input logic [6:0] cap_in);
		int n;
		int stage;
		int pos;
		int phys;
		int len;
		int cap;
		int tmp;
		res_status_t st;
		n = (mb_slots > NSLOT) ? NSLOT : int'(mb_slots);
		if (act == ACT_PUT) begin
			stage = mb_order[NSLOT] % (NSLOT + 1);
			if (mb_stage_len < MAXB) begin
				mb_bytes[stage][mb_stage_len] = db;
				mb_stage_len++;
			end else begin
				mb_ovf = 1'b1;
			end
			if (!lb) begin
				return;
			end
			if (mb_ovf || n == 0) begin
				mb_refused++;
				st = RS_REFUSED;
			end else begin
				st = RS_STORED;
				if (mb_held >= n) begin
					mb_head = (mb_head + 1) % n;
					mb_held--;
					mb_dropped++;
					st = RS_STORED_DROP;
				end
				// Commit swaps the staging slot into the ring position.
				pos = (mb_head + mb_held) % n;
				tmp = mb_order[pos];
				mb_order[pos] = mb_order[NSLOT];
				mb_order[NSLOT] = tmp;
				mb_len[stage] = 7'(mb_stage_len);
				mb_held++;
			end
			mb_stage_len = 0;
			mb_ovf = 1'b0;
			due_result(st, 8'd0, 1'b1, 0);
		end else begin
			cap = (cap_in > CAP_MAX) ? int'(CAP_MAX) : int'(cap_in);
			if (mb_held == 0 || n == 0) begin
				due_result(RS_EMPTY, 8'd0, 1'b1, 0);
				return;
			end
			phys = mb_order[mb_head % n] % (NSLOT + 1);
			len = mb_len[phys];
			if (len > MAXB) begin
				len = MAXB;
			end
			mb_head = (mb_head + 1) % n;
			mb_held--;
			if (len > cap) begin
				due_result(RS_TOO_BIG, 8'd0, 1'b1, len);
			end else if (len == 0) begin
				due_result(RS_TAKEN, 8'd0, 1'b1, 0);
			end else begin
				for (int i = 0; i < len; i++) begin
					due_result(RS_TAKEN, mb_bytes[phys][i], i + 1 == len, len);
				end
			end
		end
	endfunction

	// Prints one mismatch line (up to a limit) and counts it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_cnt++;
		if (err_cnt <= PRINT_LIMIT) begin
			$display("%0t ns: result %0d %s: got %0h, expected %0h", $realtime, result_cnt,
				what, got, want);
		end
	endtask

	// Input transfers feed the predictor; output transfers are checked in order.
	always @(posedge clk) begin
		result_t want;
		in_xfer <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			ring_step(action, data_byte, last_byte, capacity);
			accepted_cnt++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				want = results_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (out_last !== want.last)
					report_mismatch("out_last", out_last, want.last);
				if (packet_length !== want.length)
					report_mismatch("packet_length", packet_length, want.length);
				if (packets_held !== want.held)
					report_mismatch("packets_held", packets_held, want.held);
				if (dropped_total !== want.dropped)
					report_mismatch("dropped_total", dropped_total, want.dropped);
				if (refused_total !== want.refused)
					report_mismatch("refused_total", refused_total, want.refused);
			end
			result_cnt++;
		end
	end

	// Sender: holds a stalled transfer, otherwise idles at random or offers the next op.
	always @(negedge clk) begin
		ring_op_t op;
		if (!(in_valid && !in_xfer)) begin
			if (ops_to_send.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				op = ops_to_send.pop_front();
				in_valid <= 1'b1;
				action <= op.act;
				data_byte <= op.db;
				last_byte <= op.lb;
				capacity <= op.cap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once armed.
	always @(negedge clk) begin
		if (hold_armed && !hold_started) begin
			hold_started = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_put(input logic [7:0] db, input logic lb);
		ring_op_t op;
		op.act = ACT_PUT;
		op.db = db;
		op.lb = lb;
		op.cap = 7'($urandom_range(127));
		ops_to_send.push_back(op);
		queued_cnt++;
	endtask

	task automatic push_take(input logic [6:0] cap);
		ring_op_t op;
		op.act = ACT_TAKE;
		op.db = 8'($urandom_range(255));
		op.lb = 1'($urandom_range(1));
		op.cap = cap;
		ops_to_send.push_back(op);
		queued_cnt++;
	endtask

	function automatic logic [6:0] rand_cap();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 7'($urandom_range(3));
		else if (r < 40)
			return 7'($urandom_range(127));
		return 7'($urandom_range(64, 4));
	endfunction

	// A well-formed packet; now and then a take slips in between its bytes.
	task automatic gen_packet(input int len);
		for (int i = 0; i < len; i++) begin
			push_put(8'($urandom_range(255)), i + 1 == len);
			if (i + 1 < len && $urandom_range(99) < 4) begin
				push_take(rand_cap());
			end
		end
	endtask

	// Mostly short packets and takes, a few long or oversized packets, some stray takes.
	task automatic rand_traffic(input int budget);
		int start;
		int r;
		int len;
		start = queued_cnt;
		while (queued_cnt - start < budget) begin
			r = $urandom_range(99);
			if (r < 58) begin
				r = $urandom_range(99);
				if (r < 85)
					len = $urandom_range(6, 1);
				else if (r < 96)
					len = $urandom_range(40, 7);
				else
					len = $urandom_range(70, 41);
				gen_packet(len);
			end else if (r < 90) begin
				push_take(rand_cap());
			end else begin
				push_take(7'($urandom_range(127)));
			end
		end
	endtask

	// Waits until every op is taken and every result checked, then lets the block settle.
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge with the block idle.
	task automatic cfg_write(input logic [3:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		ring_config(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic partial_packet();
		for (int i = 0; i < 3; i++) begin
			push_put(8'($urandom_range(255)), 1'b0);
		end
	endtask

	initial begin
		mb_dropped = 32'd0;
		mb_refused = 32'd0;
		ring_config(SLOT_COUNT_RST);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Sender idles often, receiver idles more.
		snd_idle_pct = 37;
		rcv_idle_pct = 65;

		// Directed: empty ring, byte extremes, too big, saturated capacity,
		// take during a partial put, exact fit.
		push_take(7'd0);
		push_put(8'h00, 1'b1);
		push_put(8'hFF, 1'b0);
		push_put(8'hA5, 1'b1);
		push_take(7'd0);
		push_take(7'd127);
		push_put(8'h5A, 1'b0);
		push_take(7'd64);
		push_put(8'h3C, 1'b1);
		push_take(7'd2);
		push_take(7'd64);

		// Largest packet taken whole, then an oversized one that is refused.
		gen_packet(MAXB);
		push_take(7'd64);
		gen_packet(MAXB + 2);
		push_take(7'd127);

		rand_traffic(20);
		partial_packet();
		wait_idle();
		cfg_write(4'd3);
		rand_traffic(20);
		wait_idle();

		// Roles swapped; zero slot count refuses every packet.
		snd_idle_pct = 65;
		rcv_idle_pct = 37;
		cfg_write(4'd0);
		rand_traffic(10);
		partial_packet();
		wait_idle();
		cfg_write(4'd1);
		rand_traffic(15);
		wait_idle();

		// No idling; the long receiver hold-off backs the block up into its input.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		cfg_write(4'd15);
		hold_armed = 1'b1;
		rand_traffic(25);
		wait_idle();
		cfg_write(4'd9);
		rand_traffic(10);
		wait_idle();

		if (err_cnt == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pmr_pkg.sv
rtl/core/pmr_ring_mem.sv
rtl/core/pmr_out_q.sv
rtl/core/pdu_mailbox_ring_drop_oldest_core.sv
verif/tb_top.sv
